// ===== design/psedc_pkg.sv =====
// Package for the path segment endpoint clipper: widths, payload types,
// register map and the control structs passed between submodules.
// No dependencies.
package psedc_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  localparam int RAD_W   = COORD_BITS - 1;         // clip radius, unsigned
  localparam int DIFF_W  = COORD_BITS + 1;         // coordinate difference
  localparam int SQ_W    = 2 * DIFF_W;             // one squared component
  localparam int ACC_W   = SQ_W + 2;               // sum of three squares
  localparam int ROOT_W  = ACC_W / 2;              // distance
  localparam int REM_W   = ROOT_W + 2;             // iteration remainder
  localparam int T_W     = FRAC_BITS + 1;          // fraction incl. exact one
  localparam int NUM_W   = RAD_W + FRAC_BITS;      // divide numerator
  localparam int PROD_W  = DIFF_W + T_W + 1;       // signed diff times fraction
  localparam int CNT_W   = $clog2(ROOT_W + 1);

  localparam int NUM_REGS = 7;
  localparam int ADDR_W   = $clog2(NUM_REGS) + 2;

  localparam logic [ADDR_W-3:0] REG_START_X = 3'd0;
  localparam logic [ADDR_W-3:0] REG_START_Y = 3'd1;
  localparam logic [ADDR_W-3:0] REG_START_Z = 3'd2;
  localparam logic [ADDR_W-3:0] REG_FINAL_X = 3'd3;
  localparam logic [ADDR_W-3:0] REG_FINAL_Y = 3'd4;
  localparam logic [ADDR_W-3:0] REG_FINAL_Z = 3'd5;
  localparam logic [ADDR_W-3:0] REG_RADIUS  = 3'd6;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   is_new;
  } item_t;

  typedef struct packed {
    coord_t [2:0]     start_c;
    coord_t [2:0]     final_c;
    logic [RAD_W-1:0] radius;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_sts_t;

endpackage

// ===== design/psedc_if.sv =====
// Handshake channels of the clipper: path points in, clipped segments out.
// Depends on psedc_pkg.
interface psedc_pt_if import psedc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  logic   path_start;

  modport source(output valid, point_x, point_y, point_z, path_start, input ready);
  modport sink(input valid, point_x, point_y, point_z, path_start, output ready);
endinterface

interface psedc_seg_if import psedc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t seg_from_x;
  coord_t seg_from_y;
  coord_t seg_from_z;
  coord_t seg_to_x;
  coord_t seg_to_y;
  coord_t seg_to_z;

  modport source(output valid, seg_from_x, seg_from_y, seg_from_z,
                 seg_to_x, seg_to_y, seg_to_z, input ready);
  modport sink(input valid, seg_from_x, seg_from_y, seg_from_z,
               seg_to_x, seg_to_y, seg_to_z, output ready);
endinterface

// ===== design/path_segment_endpoint_disk_clip.sv =====
// Path segment clipper against a start sphere and a final sphere.
// Points enter on pt_i (valid/ready); each point after the first of a path
// closes a segment from the previously kept point. The segment is clipped
// against the sphere of radius clip_radius around the start center, then
// around the final center, and leaves on seg_o as one word, or is dropped
// when both ends lie inside either sphere (the kept point then stays).
// A path-start point only sets the kept point in the back end. A segment
// takes, per sphere, two distances (three squares, then the shared
// root/divide unit) and a decision, plus a divide and a cut per clipped
// end. The iterative unit sets the rate.
// A two-word queue parts input and back end, so points are taken while a
// segment is worked on; an output register holds a finished segment while
// the receiver stalls, and the back end waits there before the next one.
// Reset clears the kept point, the path state and the registers to zero.
// Start center x/y/z, final center x/y/z and clip radius are written over
// APB at byte address 4*index, by the user only while idle (not enforced).
// Depends on psedc_pkg, psedc_if, psedc_front, psedc_iter, psedc_back.
module path_segment_endpoint_disk_clip import psedc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  psedc_pt_if.sink          pt_i,
  psedc_seg_if.source       seg_o
);

  cfg_t              cfg_q;
  item_t             head;
  logic              head_valid, pop;
  logic              wr_en;
  logic [ADDR_W-3:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_START_X: cfg_q.start_c[0] <= pwdata;
        REG_START_Y: cfg_q.start_c[1] <= pwdata;
        REG_START_Z: cfg_q.start_c[2] <= pwdata;
        REG_FINAL_X: cfg_q.final_c[0] <= pwdata;
        REG_FINAL_Y: cfg_q.final_c[1] <= pwdata;
        REG_FINAL_Z: cfg_q.final_c[2] <= pwdata;
        REG_RADIUS:  cfg_q.radius     <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_X: prdata = cfg_q.start_c[0];
      REG_START_Y: prdata = cfg_q.start_c[1];
      REG_START_Z: prdata = cfg_q.start_c[2];
      REG_FINAL_X: prdata = cfg_q.final_c[0];
      REG_FINAL_Y: prdata = cfg_q.final_c[1];
      REG_FINAL_Z: prdata = cfg_q.final_c[2];
      REG_RADIUS:  prdata = {1'b0, cfg_q.radius};
      default:     prdata = '0;
    endcase
  end

  psedc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pt_i         (pt_i),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  psedc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .seg_o        (seg_o)
  );

endmodule

// ===== design/psedc_front.sv =====
// Front end: accepts path points, tags path starts and queues them in a
// two-entry FIFO for the back end. Depends on psedc_pkg and psedc_if.
module psedc_front import psedc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  psedc_pt_if.sink         pt_i,
  output item_t            head_o,
  output logic             head_valid_o,
  input  logic             pop_i
);

  item_t      fifo_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       seen_q;
  logic       push;

  assign pt_i.ready   = (cnt_q != 2'd2);
  assign push         = pt_i.valid && pt_i.ready;
  assign head_o       = fifo_q[rd_q];
  assign head_valid_o = (cnt_q != 2'd0);

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      seen_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q   <= ~wr_q;
        seen_q <= 1'b1;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
    end
  end

  // first word after reset always opens a path
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= '{x: pt_i.point_x, y: pt_i.point_y, z: pt_i.point_z,
                        is_new: pt_i.path_start || !seen_q};
    end
  end

endmodule

// ===== design/psedc_iter.sv =====
// Shared iterative unit: integer square root (two radicand bits per cycle)
// and restoring divide (one quotient bit per cycle). Depends on psedc_pkg.
module psedc_iter import psedc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iter_req_t         req_i,
  input  logic [ACC_W-1:0]  radicand_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [ROOT_W-1:0] den_i,
  output iter_sts_t         sts_o,
  output logic [ROOT_W-1:0] res_o
);

  logic              busy_q, done_q, mode_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [ACC_W-1:0]  opnd_q;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d, den_q;
  logic [REM_W-1:0]  r2, trial, r1, den_x;

  assign r2    = {rem_q[REM_W-3:0], opnd_q[ACC_W-1 -: 2]};
  assign trial = {root_q, 2'b01};
  assign r1    = {rem_q[REM_W-2:0], opnd_q[ACC_W-1]};
  assign den_x = {2'b00, den_q};

  always_comb begin
    if (mode_q) begin
      if (r2 >= trial) begin
        rem_d  = r2 - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = r2;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
    end else begin
      if (r1 >= den_x) begin
        rem_d  = r1 - den_x;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = r1;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.sqrt_mode ? CNT_W'(ROOT_W) : CNT_W'(T_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // the quotient fits T_W bits, so the divide starts with the top bits loaded
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mode_q <= req_i.sqrt_mode;
      den_q  <= den_i;
      root_q <= '0;
      if (req_i.sqrt_mode) begin
        opnd_q <= radicand_i;
        rem_q  <= '0;
      end else begin
        opnd_q <= {num_i[T_W-1:0], {(ACC_W-T_W){1'b0}}};
        rem_q  <= REM_W'(num_i[NUM_W-1:T_W]);
      end
    end else if (busy_q) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      opnd_q <= mode_q ? {opnd_q[ACC_W-3:0], 2'b00} : {opnd_q[ACC_W-2:0], 1'b0};
    end
  end

  assign sts_o = '{busy: busy_q, done: done_q};
  assign res_o = root_q;

endmodule

// ===== design/psedc_back.sv =====
// Back end: sequences distances, fractions and cuts for both spheres, holds
// the previous point and the output register. Depends on psedc_pkg,
// psedc_iter and psedc_if.
module psedc_back import psedc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  item_t       head_i,
  input  logic        head_valid_i,
  output logic        pop_o,
  psedc_seg_if.source seg_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_DEC  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_ADD  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]              st_q;
  logic                    pass_q, pt_q, sel_q;
  logic [1:0]              k_q;
  coord_t [1:0][2:0]       wp_q;
  coord_t [2:0]            last_q;
  logic [ACC_W-1:0]        acc_q, acc_d;
  logic [SQ_W-1:0]         sq_q;
  logic [ROOT_W-1:0]       d_q [2];
  logic [T_W-1:0]          t_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                    ov_q;
  coord_t [1:0][2:0]       out_q;

  iter_req_t         req;
  iter_sts_t         sts;
  logic [ROOT_W-1:0] res;
  logic [NUM_W-1:0]  num;
  logic [ROOT_W-1:0] den;

  coord_t                   ctr;
  logic signed [DIFF_W-1:0] cdiff, cutdiff;
  logic [DIFF_W-1:0]        mag;
  logic [ROOT_W-1:0]        rad_x, din, dout;
  logic                     in0, in1, out_free;
  logic signed [PROD_W-1:0] shifted;

  psedc_iter u_iter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .radicand_i (acc_d),
    .num_i      (num),
    .den_i      (den),
    .sts_o      (sts),
    .res_o      (res)
  );

  assign ctr     = pass_q ? cfg_i.final_c[k_q] : cfg_i.start_c[k_q];
  assign cdiff   = DIFF_W'(wp_q[pt_q][k_q]) - DIFF_W'(ctr);
  assign mag     = cdiff[DIFF_W-1] ? DIFF_W'(-cdiff) : DIFF_W'(cdiff);
  assign acc_d   = acc_q + ACC_W'(sq_q);
  assign rad_x   = ROOT_W'(cfg_i.radius);
  assign in0     = d_q[0] < rad_x;
  assign in1     = d_q[1] < rad_x;
  assign din     = in0 ? d_q[0] : d_q[1];
  assign dout    = in0 ? d_q[1] : d_q[0];
  assign num     = {RAD_W'(rad_x - din), {FRAC_BITS{1'b0}}};
  assign den     = dout - din;
  assign cutdiff = DIFF_W'(wp_q[~sel_q][k_q]) - DIFF_W'(wp_q[sel_q][k_q]);
  assign shifted = prod_q >>> FRAC_BITS;
  assign out_free = !ov_q || seg_o.ready;

  always_comb begin
    req   = '{start: 1'b0, sqrt_mode: 1'b0};
    pop_o = 1'b0;
    case (st_q)
      S_IDLE: pop_o = head_valid_i && head_i.is_new;
      S_ACC: begin
        req.start     = (k_q == 2'd2);
        req.sqrt_mode = 1'b1;
      end
      S_DEC: begin
        pop_o     = in0 && in1;
        req.start = in0 ^ in1;
      end
      S_OUT: pop_o = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ov_q   <= 1'b0;
      last_q <= '0;
      pass_q <= 1'b0;
      pt_q   <= 1'b0;
      k_q    <= '0;
    end else begin
      if (st_q == S_OUT && out_free) begin
        ov_q <= 1'b1;
      end else if (seg_o.ready) begin
        ov_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (head_valid_i) begin
            if (head_i.is_new) begin
              last_q <= {head_i.z, head_i.y, head_i.x};
            end else begin
              pass_q <= 1'b0;
              pt_q   <= 1'b0;
              k_q    <= '0;
              st_q   <= S_SQ;
            end
          end
        end
        S_SQ: st_q <= S_ACC;
        S_ACC: begin
          if (k_q == 2'd2) begin
            st_q <= S_SQRT;
          end else begin
            k_q  <= k_q + 2'd1;
            st_q <= S_SQ;
          end
        end
        S_SQRT: begin
          if (sts.done) begin
            k_q <= '0;
            if (!pt_q) begin
              pt_q <= 1'b1;
              st_q <= S_SQ;
            end else begin
              st_q <= S_DEC;
            end
          end
        end
        S_DEC: begin
          if (in0 && in1) begin
            st_q <= S_IDLE;     // drop; previous point stays
          end else if (in0 || in1) begin
            st_q <= S_DIV;
          end else if (!pass_q) begin
            pass_q <= 1'b1;
            pt_q   <= 1'b0;
            k_q    <= '0;
            st_q   <= S_SQ;
          end else begin
            st_q <= S_OUT;
          end
        end
        S_DIV: begin
          if (sts.done) begin
            k_q  <= '0;
            st_q <= S_MUL;
          end
        end
        S_MUL: st_q <= S_ADD;
        S_ADD: begin
          if (k_q != 2'd2) begin
            k_q  <= k_q + 2'd1;
            st_q <= S_MUL;
          end else if (!pass_q) begin
            pass_q <= 1'b1;
            pt_q   <= 1'b0;
            k_q    <= '0;
            st_q   <= S_SQ;
          end else begin
            st_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            last_q <= {head_i.z, head_i.y, head_i.x};
            st_q   <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        wp_q[0] <= last_q;
        wp_q[1] <= {head_i.z, head_i.y, head_i.x};
        acc_q   <= '0;
      end
      S_SQ: sq_q <= mag * mag;
      S_ACC: acc_q <= (k_q == 2'd2) ? '0 : acc_d;
      S_SQRT: begin
        if (sts.done) begin
          d_q[pt_q] <= res;
        end
      end
      S_DEC: sel_q <= in1;
      S_DIV: begin
        if (sts.done) begin
          t_q <= res[T_W-1:0];
        end
      end
      S_MUL: prod_q <= PROD_W'(cutdiff) * $signed({1'b0, t_q});
      S_ADD: wp_q[sel_q][k_q] <= wp_q[sel_q][k_q] + COORD_BITS'(shifted);
      S_OUT: begin
        if (out_free) begin
          out_q <= wp_q;
        end
      end
      default: ;
    endcase
  end

  assign seg_o.valid      = ov_q;
  assign seg_o.seg_from_x = out_q[0][0];
  assign seg_o.seg_from_y = out_q[0][1];
  assign seg_o.seg_from_z = out_q[0][2];
  assign seg_o.seg_to_x   = out_q[1][0];
  assign seg_o.seg_to_y   = out_q[1][1];
  assign seg_o.seg_to_z   = out_q[1][2];

endmodule
